### rtl/double_ended_queue_unit_assert.svh
// ---------------------------------------------------------------------------
// double-ended queue assertion macros
// shared concurrent assertion forms for the queue checker
// ---------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication, sampled on the rising edge, idle during reset
`define DEQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/deq_pkg.sv
// ---------------------------------------------------------------------------
// deq_pkg
// types, constants and ring helpers for the double-ended queue
// ---------------------------------------------------------------------------
package deq_pkg;

	localparam int DEPTH    = 16;
	localparam int DATA_W   = 32;
	localparam int OP_W     = 3;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;
	localparam int PTR_W    = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);

	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_SEARCH     = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SRCH,
		S_READ,
		S_LOAD
	} state_t;

	typedef struct packed {
		logic              we;
		logic [PTR_W-1:0]  waddr;
		logic [DATA_W-1:0] wdata;
		logic [PTR_W-1:0]  raddr_a;
		logic [PTR_W-1:0]  raddr_b;
	} ram_ctl_t;

	typedef struct packed {
		logic             load;
		status_t          status;
		logic             found;
		logic [CNT_W-1:0] count;
	} res_ctl_t;

	function automatic logic [PTR_W-1:0] ring_next(logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
	endfunction

	function automatic logic [PTR_W-1:0] ring_prev(logic [PTR_W-1:0] p);
		return (p == '0) ? PTR_LAST : p - PTR_W'(1);
	endfunction

	// count as reported on the result, masked to the field width
	function automatic logic [COUNT_W-1:0] to_count(logic [CNT_W-1:0] c);
		logic [CNT_W+COUNT_W-1:0] w;
		w = {{COUNT_W{1'b0}}, c};
		return w[COUNT_W-1:0];
	endfunction

endpackage

### rtl/deq_req_if.sv
// ---------------------------------------------------------------------------
// deq_req_if
// request channel: operation code and value, valid/ready handshake
// ---------------------------------------------------------------------------
interface deq_req_if;
	import deq_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          operation;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output operation, output value, input ready);
	modport sink (input valid, input operation, input value, output ready);
endinterface

### rtl/deq_res_if.sv
// ---------------------------------------------------------------------------
// deq_res_if
// result channel: status, search outcome, end values and fill state
// ---------------------------------------------------------------------------
interface deq_res_if;
	import deq_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [STATUS_W-1:0]      status;
	logic                     found;
	logic signed [DATA_W-1:0] front_value;
	logic signed [DATA_W-1:0] back_value;
	logic                     empty_res;
	logic [COUNT_W-1:0]       count;

	modport source (output valid, output status, output found, output front_value,
		output back_value, output empty_res, output count, input ready);
	modport sink (input valid, input status, input found, input front_value,
		input back_value, input empty_res, input count, output ready);
endinterface

### rtl/double_ended_queue_unit.sv
// push, pop and unused codes pass through the EXEC, READ and LOAD states, and LOAD
// waits for a free output register; a search of a non-empty ring adds SRCH, which
// walks the ring until a match or until every entry has been compared
// requests: a new one is taken only in IDLE, once the last result has been loaded;
// the serial compare walks the ring through read port a
// reset: arst_n clears pointers, count and handshake state; the ring holds no reset
// ---------------------------------------------------------------------------
// double_ended_queue_unit
// double-ended queue of signed 32-bit values in a ring with serial search
// ---------------------------------------------------------------------------
module double_ended_queue_unit (
	input  logic      clk,
	input  logic      arst_n,
	deq_req_if.sink   req,
	deq_res_if.source res
);
	import deq_pkg::*;

	ram_ctl_t          ram_ctl;
	res_ctl_t          res_ctl;
	logic [DATA_W-1:0] rdata_a;
	logic [DATA_W-1:0] rdata_b;
	logic              seq_ready;
	logic              req_fire;
	logic              res_free;
	logic              res_valid_q;

	// request taken only while the sequencer sits idle
	assign req.ready = seq_ready;
	assign req_fire  = req.valid && seq_ready;

	// the output register can take a new result when empty or being drained
	assign res_free = !res_valid_q || res.ready;

	// ring storage: write on push, port a for the front and the search walk,
	// port b for the back entry
	deq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (ram_ctl.we),
		.waddr   (ram_ctl.waddr),
		.wdata   (ram_ctl.wdata),
		.raddr_a (ram_ctl.raddr_a),
		.raddr_b (ram_ctl.raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// sequencer owns pointers, count and the compare loop
	deq_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_fire  (req_fire),
		.operation (req.operation),
		.value     (req.value),
		.rdata_a   (rdata_a),
		.res_free  (res_free),
		.ready     (seq_ready),
		.ram_ctl   (ram_ctl),
		.res_ctl   (res_ctl)
	);

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_ctl.load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload, end values forced to zero when the ring is empty
	always_ff @(posedge clk) begin
		if (res_ctl.load) begin
			res.status      <= res_ctl.status;
			res.found       <= res_ctl.found;
			res.empty_res   <= (res_ctl.count == '0);
			res.count       <= to_count(res_ctl.count);
			res.front_value <= (res_ctl.count == '0) ? '0 : rdata_a;
			res.back_value  <= (res_ctl.count == '0) ? '0 : rdata_b;
		end
	end

	assign res.valid = res_valid_q;
endmodule

### rtl/deq_ram.sv
// ---------------------------------------------------------------------------
// deq_ram
// generic ram, one write port and two registered read ports
// ---------------------------------------------------------------------------
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end
endmodule

### rtl/deq_seq.sv
// ---------------------------------------------------------------------------
// deq_seq
// sequencer: ring pointers, count, push/pop update and serial key search
// ---------------------------------------------------------------------------
module deq_seq (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_fire,
	input  logic [deq_pkg::OP_W-1:0]         operation,
	input  logic [deq_pkg::DATA_W-1:0]       value,
	input  logic [deq_pkg::DATA_W-1:0]       rdata_a,
	input  logic                             res_free,
	output logic                             ready,
	output deq_pkg::ram_ctl_t                ram_ctl,
	output deq_pkg::res_ctl_t                res_ctl
);
	import deq_pkg::*;

	state_t            state_q, state_d;
	logic [OP_W-1:0]   op_q;
	logic [DATA_W-1:0] key_q;
	logic [PTR_W-1:0]  front_q, front_d;
	logic [PTR_W-1:0]  back_q, back_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	status_t           status_q, status_d;
	logic              found_q, found_d;
	logic [CNT_W-1:0]  idx_q, idx_d;
	logic [PTR_W-1:0]  sp_q, sp_d;
	logic              pend_q, pend_d;
	logic              issue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			front_q  <= '0;
			back_q   <= '0;
			cnt_q    <= '0;
			status_q <= ST_DONE;
			found_q  <= 1'b0;
			idx_q    <= '0;
			sp_q     <= '0;
			pend_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			front_q  <= front_d;
			back_q   <= back_d;
			cnt_q    <= cnt_d;
			status_q <= status_d;
			found_q  <= found_d;
			idx_q    <= idx_d;
			sp_q     <= sp_d;
			pend_q   <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_q  <= operation;
			key_q <= value;
		end
	end

	assign issue = (idx_q < cnt_q);

	always_comb begin
		state_d  = state_q;
		front_d  = front_q;
		back_d   = back_q;
		cnt_d    = cnt_q;
		status_d = status_q;
		found_d  = found_q;
		idx_d    = idx_q;
		sp_d     = sp_q;
		pend_d   = pend_q;
		ready    = 1'b0;

		ram_ctl.we      = 1'b0;
		ram_ctl.waddr   = back_q;
		ram_ctl.wdata   = key_q;
		ram_ctl.raddr_a = front_q;
		ram_ctl.raddr_b = ring_prev(back_q);

		res_ctl.load   = 1'b0;
		res_ctl.status = status_q;
		res_ctl.found  = found_q;
		res_ctl.count  = cnt_q;

		unique case (state_q)
			S_IDLE: begin
				ready = 1'b1;
				if (req_fire) begin
					status_d = ST_DONE;
					found_d  = 1'b0;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_READ;
				unique case (op_q)
					OP_PUSH_FRONT: begin
						if (cnt_q >= CNT_FULL) begin
							status_d = ST_FULL;
						end else begin
							ram_ctl.we    = 1'b1;
							ram_ctl.waddr = ring_prev(front_q);
							front_d       = ring_prev(front_q);
							cnt_d         = cnt_q + CNT_W'(1);
						end
					end
					OP_PUSH_BACK: begin
						if (cnt_q >= CNT_FULL) begin
							status_d = ST_FULL;
						end else begin
							ram_ctl.we = 1'b1;
							back_d     = ring_next(back_q);
							cnt_d      = cnt_q + CNT_W'(1);
						end
					end
					OP_POP_FRONT: begin
						if (cnt_q == '0) begin
							status_d = ST_EMPTY;
						end else begin
							front_d = ring_next(front_q);
							cnt_d   = cnt_q - CNT_W'(1);
						end
					end
					OP_POP_BACK: begin
						if (cnt_q == '0) begin
							status_d = ST_EMPTY;
						end else begin
							back_d = ring_prev(back_q);
							cnt_d  = cnt_q - CNT_W'(1);
						end
					end
					OP_SEARCH: begin
						idx_d  = '0;
						sp_d   = front_q;
						pend_d = 1'b0;
						if (cnt_q != '0) begin
							state_d = S_SRCH;
						end
					end
					default: begin
						// unused codes leave pointers, count and status as they are
					end
				endcase
			end
			S_SRCH: begin
				// each cycle, one read is issued while entries remain and the pending read is compared
				ram_ctl.raddr_a = sp_q;
				if (issue) begin
					idx_d = idx_q + CNT_W'(1);
					sp_d  = ring_next(sp_q);
				end
				pend_d = issue;
				if (pend_q && (rdata_a == key_q)) begin
					found_d = 1'b1;
					state_d = S_READ;
				end else if (!issue && !pend_q) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				state_d = S_LOAD;
			end
			S_LOAD: begin
				if (res_free) begin
					res_ctl.load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule

### rtl/deq_chk.sv
// ---------------------------------------------------------------------------
// deq_chk
// port-level checks for the double-ended queue, bound to the top level
// ---------------------------------------------------------------------------
`include "double_ended_queue_unit_assert.svh"

module deq_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic [deq_pkg::STATUS_W-1:0]  status,
	input logic [deq_pkg::DATA_W-1:0]    front_value,
	input logic [deq_pkg::DATA_W-1:0]    back_value,
	input logic                          empty_res,
	input logic [deq_pkg::COUNT_W-1:0]   count
);
	import deq_pkg::*;

	// a result waiting for the sink is not dropped
	`DEQ_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "result dropped")

	// one request at a time: ready falls once a request is taken
	`DEQ_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "ready held after request")

	// empty flag agrees with the count
	`DEQ_ASSERT_NOW(a_empty_count, res_valid, empty_res == (count == '0), "empty flag mismatch")

	// an empty ring reports zero at both ends
	`DEQ_ASSERT_NOW(a_empty_zero, res_valid && empty_res, front_value == '0 && back_value == '0, "non-zero ends when empty")

	// a refused push only happens at full occupancy
	`DEQ_ASSERT_NOW(a_full_count, res_valid && status == ST_FULL, count == COUNT_W'(DEPTH), "full status below capacity")
endmodule

bind double_ended_queue_unit deq_chk u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.status      (res.status),
	.front_value (res.front_value),
	.back_value  (res.back_value),
	.empty_res   (res.empty_res),
	.count       (res.count)
);
